@@ design/ordered_list_table_engine_macros.svh @@
// Assertion macros for the ordered list table engine.
// Included by olte_ctrl, the RTL file that carries concurrent checks; no other dependencies.
`ifndef ORDERED_LIST_TABLE_ENGINE_MACROS_SVH
`define ORDERED_LIST_TABLE_ENGINE_MACROS_SVH
`ifndef SYNTH
`define OLTE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olte: same-cycle check failed");
`define OLTE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olte: next-cycle check failed");
`else
`define OLTE_ASSERT_IMP(label, clk, rst, ante, cons)
`define OLTE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/olte_pkg.sv @@
// Shared types and codes for the ordered list table engine.
// No dependencies; used by the cell, the controller and the top level.
`default_nettype none

package olte_pkg;

   typedef enum logic [2:0] {
      OP_APPEND        = 3'd0,
      OP_POP_END       = 3'd1,
      OP_PUSH_FRONT    = 3'd2,
      OP_POP_FRONT     = 3'd3,
      OP_LOOKUP        = 3'd4,
      OP_INSERT_BEFORE = 3'd5,
      OP_REMOVE_CODE   = 3'd6,
      OP_CLEAR         = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // which cell an operation singles out
   typedef enum logic [1:0] {
      SEL_MATCH = 2'd0,
      SEL_FIRST = 2'd1,
      SEL_LAST  = 2'd2,
      SEL_TAIL  = 2'd3
   } sel_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_APPLY = 2'd2
   } state_type;

   typedef struct packed {
      logic [31:0]        weight;
      logic signed [31:0] code;
   } entry_type;

   typedef struct packed {
      sel_mode_type sel;
      logic         shift_up;
      logic         shift_down;
   } cell_ctl_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] search_code;
      logic signed [31:0] item_code;
      logic [31:0]        item_weight;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_code;
      logic [31:0]        out_weight;
      logic [4:0]         entry_count;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/olte_cell.sv @@
// One list cell: holds one entry and the two scan chains at its position.
// Depends on olte_pkg.
`default_nettype none

module olte_cell #(
   parameter int DEPTH    = 16,
   parameter int CELL_IDX = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire olte_pkg::cell_ctl_type       ctl,
   input  wire logic [$clog2(DEPTH+1)-1:0]   count,
   input  wire logic signed [31:0]           search_code,
   input  wire olte_pkg::entry_type          item,
   input  wire olte_pkg::entry_type          left_entry,
   input  wire logic                         left_prefix,
   input  wire olte_pkg::entry_type          right_entry,
   input  wire logic                         right_hit,
   input  wire olte_pkg::entry_type          right_hit_entry,
   output olte_pkg::entry_type               entry,
   output logic                              prefix,
   output logic                              hit,
   output olte_pkg::entry_type               hit_entry
);
   import olte_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   entry_type entry_ff, entry_in;
   entry_type hit_entry_ff, hit_entry_in;
   logic      prefix_ff, prefix_in;
   logic      hit_ff, hit_in;
   logic      valid;
   logic      sel;

   assign valid = count > CW'(CELL_IDX);

   always_comb begin
      unique case (ctl.sel)
         SEL_MATCH: sel = valid && (entry_ff.code == search_code);
         SEL_FIRST: sel = (CELL_IDX == 0);
         SEL_LAST:  sel = (count == CW'(CELL_IDX + 1));
         SEL_TAIL:  sel = (count == CW'(CELL_IDX));
         default:   sel = 1'b0;
      endcase
   end

   // forward chain marks the selected cell and all after it;
   // backward chain brings the first selected entry down to cell 0
   always_comb begin
      prefix_in    = left_prefix | sel;
      hit_in       = sel | right_hit;
      hit_entry_in = sel ? entry_ff : right_hit_entry;
      entry_in     = entry_ff;
      if (ctl.shift_up && prefix_ff) begin
         entry_in = left_prefix ? left_entry : item;
      end else if (ctl.shift_down && prefix_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      hit_entry_ff <= hit_entry_in;
   end

   assign entry     = entry_ff;
   assign prefix    = prefix_ff;
   assign hit       = hit_ff;
   assign hit_entry = hit_entry_ff;

endmodule

`default_nettype wire

@@ design/olte_ctrl.sv @@
// Sequencer for the list: latches an item, lets the cell chains settle,
// then commits the shift and builds the result. Depends on olte_pkg and the macros.
`default_nettype none
`include "ordered_list_table_engine_macros.svh"

module olte_ctrl #(
   parameter int DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire olte_pkg::req_type            req_item,
   input  wire logic                         hit0,
   input  wire olte_pkg::entry_type          hit_entry0,
   output olte_pkg::cell_ctl_type            ctl,
   output logic [$clog2(DEPTH+1)-1:0]        count,
   output logic signed [31:0]                search_code,
   output olte_pkg::entry_type               item,
   output logic                              rsp_valid,
   output olte_pkg::rsp_type                 rsp_item
);
   import olte_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  scan_ff, scan_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      logic        full_now;
      logic        empty_now;
      logic        take;
      status_type  stat;
      logic [CW-1:0] cnt_n;
      logic [31:0] cnt_wide;

      full_now     = (cnt_ff == CW'(DEPTH));
      empty_now    = (cnt_ff == '0);
      take         = 1'b0;
      stat         = STAT_OK;
      cnt_n        = cnt_ff;
      cnt_wide     = '0;

      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      ctl.shift_up   = 1'b0;
      ctl.shift_down = 1'b0;
      unique case (req_ff.func) inside
         OP_APPEND:                               ctl.sel = SEL_TAIL;
         OP_POP_END:                              ctl.sel = SEL_LAST;
         OP_PUSH_FRONT, OP_POP_FRONT, OP_CLEAR:   ctl.sel = SEL_FIRST;
         default:                                 ctl.sel = SEL_MATCH;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == CW'(DEPTH - 1)) begin
               state_in = ST_APPLY;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_APPLY: begin
            unique case (req_ff.func) inside
               OP_APPEND, OP_PUSH_FRONT: begin
                  if (full_now) begin
                     stat = STAT_FULL;
                  end else begin
                     ctl.shift_up = 1'b1;
                     cnt_n = cnt_ff + 1'b1;
                  end
               end
               OP_POP_END: begin
                  if (empty_now) begin
                     stat = STAT_EMPTY;
                  end else begin
                     take  = 1'b1;
                     cnt_n = cnt_ff - 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (empty_now) begin
                     stat = STAT_EMPTY;
                  end else begin
                     take = 1'b1;
                     ctl.shift_down = 1'b1;
                     cnt_n = cnt_ff - 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  if (!hit0) begin
                     stat = STAT_NOT_FOUND;
                  end else begin
                     take = 1'b1;
                  end
               end
               OP_INSERT_BEFORE: begin
                  if (full_now) begin
                     stat = STAT_FULL;
                  end else if (!hit0) begin
                     stat = STAT_NOT_FOUND;
                  end else begin
                     ctl.shift_up = 1'b1;
                     cnt_n = cnt_ff + 1'b1;
                  end
               end
               OP_REMOVE_CODE: begin
                  if (!hit0) begin
                     stat = STAT_NOT_FOUND;
                  end else begin
                     take = 1'b1;
                     ctl.shift_down = 1'b1;
                     cnt_n = cnt_ff - 1'b1;
                  end
               end
               OP_CLEAR: cnt_n = '0;
               default:  cnt_n = cnt_ff;
            endcase
            cnt_wide             = 32'(cnt_n);
            cnt_in               = cnt_n;
            rsp_in.status        = stat;
            rsp_in.out_code      = take ? hit_entry0.code : '0;
            rsp_in.out_weight    = take ? hit_entry0.weight : '0;
            rsp_in.entry_count   = cnt_wide[4:0];
            rsp_in.is_full       = (cnt_n == CW'(DEPTH));
            rsp_in.is_empty      = (cnt_n == '0);
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy        = (state_ff != ST_IDLE);
   assign count       = cnt_ff;
   assign search_code = req_ff.search_code;
   assign item.code   = req_ff.item_code;
   assign item.weight = req_ff.item_weight;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_ff;

   `OLTE_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `OLTE_ASSERT_NXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `OLTE_ASSERT_NXT(a_accept_scan, clock, reset, start && state_ff == ST_IDLE, state_ff == ST_SCAN)
   `OLTE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CW'(DEPTH))
   `OLTE_ASSERT_IMP(a_full_flag, clock, reset, rsp_valid_ff && rsp_ff.status == STAT_FULL, rsp_ff.is_full)

endmodule

`default_nettype wire

@@ design/ordered_list_table_engine.sv @@
// Top level of the ordered list table engine: a row of list cells and its sequencer.
// Depends on olte_pkg, olte_cell and olte_ctrl.
//
// Usage:
//   Drive req_item and raise start; the item is taken at a rising edge with
//   start high and busy low. busy stays high while the operation runs.
//   Each item yields one result on rsp_item, shown for one cycle with rsp_valid.
//   Sequence: a scan state, while the match and selection chains settle
//   through the cell row, then an apply state that commits the shift; the
//   result strobe is registered from it. busy drops in the strobe cycle,
//   so a new item can be taken then, but not before the last one is done.
//   Shifts are done at once: each cell from the selected one on loads a neighbor or the item.
//   Reset (synchronous, active high) empties the list and drops busy and
//   rsp_valid; stored entries are not cleared and need no sweep.
//   The receiver cannot stall: a result is taken in its strobe cycle.
//   entry_count reports the count modulo 32.
`default_nettype none

module ordered_list_table_engine #(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire olte_pkg::req_type req_item,
   output logic                   rsp_valid,
   output olte_pkg::rsp_type      rsp_item
);
   import olte_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   cell_ctl_type       ctl;
   logic [CW-1:0]      count;
   logic signed [31:0] search_code;
   entry_type          item;

   // padded chains: ent[i+1] is cell i, pre[i+1] is cell i prefix
   entry_type ent [0:DEPTH+1];
   logic      pre [0:DEPTH];
   logic      hit [0:DEPTH];
   entry_type hent [0:DEPTH];

   assign ent[0]         = '0;
   assign ent[DEPTH+1]   = '0;
   assign pre[0]         = 1'b0;
   assign hit[DEPTH]     = 1'b0;
   assign hent[DEPTH]    = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      olte_cell #(
         .DEPTH    (DEPTH),
         .CELL_IDX (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctl             (ctl),
         .count           (count),
         .search_code     (search_code),
         .item            (item),
         .left_entry      (ent[i]),
         .left_prefix     (pre[i]),
         .right_entry     (ent[i+2]),
         .right_hit       (hit[i+1]),
         .right_hit_entry (hent[i+1]),
         .entry           (ent[i+1]),
         .prefix          (pre[i+1]),
         .hit             (hit[i]),
         .hit_entry       (hent[i])
      );
   end

   olte_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .hit0        (hit[0]),
      .hit_entry0  (hent[0]),
      .ctl         (ctl),
      .count       (count),
      .search_code (search_code),
      .item        (item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire
